### rtl/lrtp_pkg.sv
package lrtp_pkg;

    localparam int COORD_FRAC_BITS = 16;

    localparam int COORD_W = 32;   // point and result coordinates
    localparam int REG_W   = 31;   // configuration registers
    localparam int RAD_W   = 66;   // x^2 + c^2, padded to an even width
    localparam int ROOT_W  = RAD_W / 2;
    localparam int SREM_W  = ROOT_W + 3;
    localparam int NUM_W   = 63;   // |coordinate| * R
    localparam int DREM_W  = ROOT_W;

    localparam logic [REG_W-1:0] REG_ONE = REG_W'(1) << COORD_FRAC_BITS;

    localparam logic [1:0] CFG_HALF_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HALF_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_ARC_RADIUS  = 2'd2;

    typedef struct packed {
        logic upper;    // point on the upper side (y >= 0)
        logic neg_x;
        logic neg_c;
        logic in_lens;
    } flag_t;

    typedef struct packed {
        flag_t            flags;
        logic [NUM_W-1:0] num_x;
        logic [NUM_W-1:0] num_c;
    } sq_side_t;

endpackage

### rtl/lens_region_test_and_project.sv
// Lens region point test and boundary projection. Takes one point (signed
// fixed point) per cycle while the output buffer has room, and returns an
// inside flag and the point projected radially onto the arc of its side,
// snapped to a corner when it crosses the x axis. An accepted point passes
// four front stages (magnitudes, squares and products, sums), 33 square-root
// cells that each resolve one root bit, and 63 divider cells that each
// resolve one quotient bit of both coordinates, then a two-word output
// buffer. Throughput is one point per cycle while the output buffer has
// room. Write configuration only while no point is in flight.
module lens_region_test_and_project #(
    parameter int COORD_FRAC_BITS = lrtp_pkg::COORD_FRAC_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [31:0]          s_point_x,
    input  logic signed [31:0]          s_point_y,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_is_inside,
    output logic signed [31:0]          m_proj_x,
    output logic signed [31:0]          m_proj_y,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [31:0]                 cfg_data
);

    localparam int SQ_N  = lrtp_pkg::ROOT_W;
    localparam int DIV_N = lrtp_pkg::NUM_W;

    // 1.0 in the point format
    localparam logic [lrtp_pkg::REG_W-1:0] REG_ONE =
        {{(lrtp_pkg::REG_W-1){1'b0}}, 1'b1} << COORD_FRAC_BITS;

    logic [lrtp_pkg::REG_W-1:0] half_width_reg;
    logic [lrtp_pkg::REG_W-1:0] half_height_reg;
    logic [lrtp_pkg::REG_W-1:0] arc_radius_reg;
    logic [2*lrtp_pkg::REG_W-1:0] rr_reg;

    logic en;

    // input stage
    logic               v0_reg;
    logic signed [31:0] x0_reg;
    logic signed [31:0] y0_reg;

    // stage A
    logic signed [32:0] off;
    logic signed [33:0] c_a;
    logic signed [33:0] d_a;
    logic [31:0]        ax_a;
    logic [31:0]        ay_a;
    logic [31:0]        ac_a;
    logic [31:0]        ad_a;
    logic               va_reg;
    logic [31:0]        ax_reg;
    logic [31:0]        ac_reg;
    logic [31:0]        ad_reg;
    lrtp_pkg::flag_t    fa_reg;

    // stage B
    logic               vb_reg;
    logic [63:0]        x2_reg;
    logic [63:0]        c2_reg;
    logic [63:0]        d2_reg;
    logic [lrtp_pkg::NUM_W-1:0] nx_b_reg;
    logic [lrtp_pkg::NUM_W-1:0] nc_b_reg;
    lrtp_pkg::flag_t    fb_reg;

    // stage C
    logic               vc_reg;
    logic [64:0]        sum_reg;
    lrtp_pkg::sq_side_t sc_reg;

    // square-root chain
    logic                        sq_v    [0:SQ_N];
    logic [lrtp_pkg::RAD_W-1:0]  sq_rad  [0:SQ_N];
    logic [lrtp_pkg::SREM_W-1:0] sq_rem  [0:SQ_N];
    logic [lrtp_pkg::ROOT_W-1:0] sq_root [0:SQ_N];
    lrtp_pkg::sq_side_t          sq_side [0:SQ_N];

    // divider chain
    logic                        dv_v    [0:DIV_N];
    lrtp_pkg::flag_t             dv_f    [0:DIV_N];
    logic [lrtp_pkg::ROOT_W-1:0] dv_dist [0:DIV_N];
    logic [lrtp_pkg::NUM_W-1:0]  dv_nx   [0:DIV_N];
    logic [lrtp_pkg::NUM_W-1:0]  dv_nc   [0:DIV_N];
    logic [lrtp_pkg::DREM_W-1:0] dv_rx   [0:DIV_N];
    logic [lrtp_pkg::DREM_W-1:0] dv_rc   [0:DIV_N];
    logic [lrtp_pkg::NUM_W-1:0]  dv_qx   [0:DIV_N];
    logic [lrtp_pkg::NUM_W-1:0]  dv_qc   [0:DIV_N];

    // final stage
    lrtp_pkg::flag_t    ft;
    logic               dz;
    logic signed [63:0] px;
    logic signed [64:0] qv;
    logic signed [65:0] py;
    logic               snap;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic               push;
    logic               pop;

    // output buffer
    logic [1:0]         cnt_reg;
    logic               wp_reg;
    logic               rp_reg;
    logic               ob_in_reg [0:1];
    logic signed [31:0] ob_x_reg  [0:1];
    logic signed [31:0] ob_y_reg  [0:1];

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_width_reg  <= REG_ONE;
            half_height_reg <= REG_ONE;
            arc_radius_reg  <= REG_ONE;
        end else if (cfg_valid) begin
            case (cfg_index)
                lrtp_pkg::CFG_HALF_WIDTH:  half_width_reg  <= cfg_data[lrtp_pkg::REG_W-1:0];
                lrtp_pkg::CFG_HALF_HEIGHT: half_height_reg <= cfg_data[lrtp_pkg::REG_W-1:0];
                lrtp_pkg::CFG_ARC_RADIUS:  arc_radius_reg  <= cfg_data[lrtp_pkg::REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        rr_reg <= arc_radius_reg * arc_radius_reg;
    end

    // whole chain advances while the output buffer has room
    assign en      = cnt_reg != 2'd2;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
            va_reg <= v0_reg;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg <= s_point_x;
            y0_reg <= s_point_y;
        end
    end

    // stage A: signed offsets, magnitudes and box test
    assign off  = $signed({2'b00, arc_radius_reg}) - $signed({2'b00, half_height_reg});
    assign c_a  = y0_reg[31] ? 34'(y0_reg) - 34'(off) : 34'(y0_reg) + 34'(off);
    assign ax_a = x0_reg[31] ? 32'(-x0_reg) : 32'(x0_reg);
    assign ay_a = y0_reg[31] ? 32'(-y0_reg) : 32'(y0_reg);
    assign ac_a = c_a[33] ? 32'(-c_a) : 32'(c_a);
    assign d_a  = $signed({2'b00, ay_a}) - $signed({3'b000, half_height_reg})
                + $signed({3'b000, arc_radius_reg});
    assign ad_a = d_a[33] ? 32'(-d_a) : 32'(d_a);

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg         <= ax_a;
            ac_reg         <= ac_a;
            ad_reg         <= ad_a;
            fa_reg.upper   <= !y0_reg[31];
            fa_reg.neg_x   <= x0_reg[31];
            fa_reg.neg_c   <= c_a[33];
            fa_reg.in_lens <= (ax_a <= {1'b0, half_width_reg})
                           && (ay_a <= {1'b0, half_height_reg});
        end
    end

    // stage B: squares and numerators
    always_ff @(posedge aclk) begin
        if (en) begin
            x2_reg   <= ax_reg * ax_reg;
            c2_reg   <= ac_reg * ac_reg;
            d2_reg   <= ad_reg * ad_reg;
            nx_b_reg <= ax_reg * arc_radius_reg;
            nc_b_reg <= ac_reg * arc_radius_reg;
            fb_reg   <= fa_reg;
        end
    end

    // stage C: radicand and circle test
    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg              <= {1'b0, x2_reg} + {1'b0, c2_reg};
            sc_reg.num_x         <= nx_b_reg;
            sc_reg.num_c         <= nc_b_reg;
            sc_reg.flags.upper   <= fb_reg.upper;
            sc_reg.flags.neg_x   <= fb_reg.neg_x;
            sc_reg.flags.neg_c   <= fb_reg.neg_c;
            sc_reg.flags.in_lens <= fb_reg.in_lens
                && (({1'b0, x2_reg} + {1'b0, d2_reg}) <= {3'b000, rr_reg});
        end
    end

    assign sq_v[0]    = vc_reg;
    assign sq_rad[0]  = {1'b0, sum_reg};
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = sc_reg;

    for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
        lrtp_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sq_v[i]),
            .in_rad    (sq_rad[i]),
            .in_rem    (sq_rem[i]),
            .in_root   (sq_root[i]),
            .in_side   (sq_side[i]),
            .out_valid (sq_v[i+1]),
            .out_rad   (sq_rad[i+1]),
            .out_rem   (sq_rem[i+1]),
            .out_root  (sq_root[i+1]),
            .out_side  (sq_side[i+1])
        );
    end

    assign dv_v[0]    = sq_v[SQ_N];
    assign dv_f[0]    = sq_side[SQ_N].flags;
    assign dv_dist[0] = sq_root[SQ_N];
    assign dv_nx[0]   = sq_side[SQ_N].num_x;
    assign dv_nc[0]   = sq_side[SQ_N].num_c;
    assign dv_rx[0]   = '0;
    assign dv_rc[0]   = '0;
    assign dv_qx[0]   = '0;
    assign dv_qc[0]   = '0;

    for (genvar i = 0; i < DIV_N; i++) begin : g_div
        lrtp_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (dv_v[i]),
            .in_flags  (dv_f[i]),
            .in_dist   (dv_dist[i]),
            .in_num_x  (dv_nx[i]),
            .in_num_c  (dv_nc[i]),
            .in_rem_x  (dv_rx[i]),
            .in_rem_c  (dv_rc[i]),
            .in_quo_x  (dv_qx[i]),
            .in_quo_c  (dv_qc[i]),
            .out_valid (dv_v[i+1]),
            .out_flags (dv_f[i+1]),
            .out_dist  (dv_dist[i+1]),
            .out_num_x (dv_nx[i+1]),
            .out_num_c (dv_nc[i+1]),
            .out_rem_x (dv_rx[i+1]),
            .out_rem_c (dv_rc[i+1]),
            .out_quo_x (dv_qx[i+1]),
            .out_quo_c (dv_qc[i+1])
        );
    end

    // final: signs, arc centre case, snap and saturate
    assign ft = dv_f[DIV_N];
    assign dz = dv_dist[DIV_N] == '0;

    always_comb begin
        if (dz) begin
            px = '0;
            qv = ft.upper ? $signed({34'd0, arc_radius_reg})
                          : -$signed({34'd0, arc_radius_reg});
        end else begin
            px = ft.neg_x ? -$signed({1'b0, dv_qx[DIV_N]}) : $signed({1'b0, dv_qx[DIV_N]});
            qv = ft.neg_c ? -$signed({2'b00, dv_qc[DIV_N]}) : $signed({2'b00, dv_qc[DIV_N]});
        end
        py   = ft.upper ? 66'(qv) - 66'(off) : 66'(qv) + 66'(off);
        snap = ft.upper ? (py <= 0) : (py >= 0);
        if (snap) begin
            fx = (px > 0) ? $signed({1'b0, half_width_reg}) : -$signed({1'b0, half_width_reg});
            fy = '0;
        end else begin
            if (px > 64'sh7FFF_FFFF) begin
                fx = 32'sh7FFF_FFFF;
            end else if (px < -64'sh8000_0000) begin
                fx = 32'sh8000_0000;
            end else begin
                fx = px[31:0];
            end
            if (py > 66'sh7FFF_FFFF) begin
                fy = 32'sh7FFF_FFFF;
            end else if (py < -66'sh8000_0000) begin
                fy = 32'sh8000_0000;
            end else begin
                fy = py[31:0];
            end
        end
    end

    // two-word output buffer
    assign push = en && dv_v[DIV_N];
    assign pop  = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
            if (push) begin
                wp_reg <= !wp_reg;
            end
            if (pop) begin
                rp_reg <= !rp_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ob_in_reg[wp_reg] <= ft.in_lens;
            ob_x_reg[wp_reg]  <= fx;
            ob_y_reg[wp_reg]  <= fy;
        end
    end

    assign m_valid     = cnt_reg != 2'd0;
    assign m_is_inside = ob_in_reg[rp_reg];
    assign m_proj_x    = ob_x_reg[rp_reg];
    assign m_proj_y    = ob_y_reg[rp_reg];

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'd2)
        else $error("output buffer overflow");

    a_full_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2 && !pop) |=> cnt_reg == 2'd2)
        else $error("word written into full output buffer");

    a_accept_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> cnt_reg != 2'd2)
        else $error("point taken while chain stalled");

endmodule

### rtl/lrtp_sqrt_cell.sv
module lrtp_sqrt_cell (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [lrtp_pkg::RAD_W-1:0]       in_rad,
    input  logic [lrtp_pkg::SREM_W-1:0]      in_rem,
    input  logic [lrtp_pkg::ROOT_W-1:0]      in_root,
    input  lrtp_pkg::sq_side_t               in_side,
    output logic                             out_valid,
    output logic [lrtp_pkg::RAD_W-1:0]       out_rad,
    output logic [lrtp_pkg::SREM_W-1:0]      out_rem,
    output logic [lrtp_pkg::ROOT_W-1:0]      out_root,
    output lrtp_pkg::sq_side_t               out_side
);

    logic [lrtp_pkg::SREM_W-1:0] rem_sh;
    logic [lrtp_pkg::SREM_W-1:0] trial;
    logic                        ge;
    logic                        valid_reg;
    logic [lrtp_pkg::RAD_W-1:0]  rad_reg;
    logic [lrtp_pkg::SREM_W-1:0] rem_reg;
    logic [lrtp_pkg::ROOT_W-1:0] root_reg;
    lrtp_pkg::sq_side_t          side_reg;

    // bring down the next two radicand bits, try 4*root+1
    assign rem_sh = {in_rem[lrtp_pkg::SREM_W-3:0], in_rad[lrtp_pkg::RAD_W-1 -: 2]};
    assign trial  = {1'b0, in_root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg  <= {in_rad[lrtp_pkg::RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? rem_sh - trial : rem_sh;
            root_reg <= {in_root[lrtp_pkg::ROOT_W-2:0], ge};
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule

### rtl/lrtp_div_cell.sv
module lrtp_div_cell (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  lrtp_pkg::flag_t                  in_flags,
    input  logic [lrtp_pkg::ROOT_W-1:0]      in_dist,
    input  logic [lrtp_pkg::NUM_W-1:0]       in_num_x,
    input  logic [lrtp_pkg::NUM_W-1:0]       in_num_c,
    input  logic [lrtp_pkg::DREM_W-1:0]      in_rem_x,
    input  logic [lrtp_pkg::DREM_W-1:0]      in_rem_c,
    input  logic [lrtp_pkg::NUM_W-1:0]       in_quo_x,
    input  logic [lrtp_pkg::NUM_W-1:0]       in_quo_c,
    output logic                             out_valid,
    output lrtp_pkg::flag_t                  out_flags,
    output logic [lrtp_pkg::ROOT_W-1:0]      out_dist,
    output logic [lrtp_pkg::NUM_W-1:0]       out_num_x,
    output logic [lrtp_pkg::NUM_W-1:0]       out_num_c,
    output logic [lrtp_pkg::DREM_W-1:0]      out_rem_x,
    output logic [lrtp_pkg::DREM_W-1:0]      out_rem_c,
    output logic [lrtp_pkg::NUM_W-1:0]       out_quo_x,
    output logic [lrtp_pkg::NUM_W-1:0]       out_quo_c
);

    logic [lrtp_pkg::DREM_W:0]   sh_x;
    logic [lrtp_pkg::DREM_W:0]   sh_c;
    logic [lrtp_pkg::DREM_W:0]   dvs;
    logic [lrtp_pkg::DREM_W:0]   dif_x;
    logic [lrtp_pkg::DREM_W:0]   dif_c;
    logic                        ge_x;
    logic                        ge_c;
    logic                        valid_reg;
    lrtp_pkg::flag_t             flags_reg;
    logic [lrtp_pkg::ROOT_W-1:0] dist_reg;
    logic [lrtp_pkg::NUM_W-1:0]  num_x_reg;
    logic [lrtp_pkg::NUM_W-1:0]  num_c_reg;
    logic [lrtp_pkg::DREM_W-1:0] rem_x_reg;
    logic [lrtp_pkg::DREM_W-1:0] rem_c_reg;
    logic [lrtp_pkg::NUM_W-1:0]  quo_x_reg;
    logic [lrtp_pkg::NUM_W-1:0]  quo_c_reg;

    // one restoring step on each lane, same divisor
    assign dvs   = {1'b0, in_dist};
    assign sh_x  = {in_rem_x, in_num_x[lrtp_pkg::NUM_W-1]};
    assign sh_c  = {in_rem_c, in_num_c[lrtp_pkg::NUM_W-1]};
    assign ge_x  = sh_x >= dvs;
    assign ge_c  = sh_c >= dvs;
    assign dif_x = ge_x ? sh_x - dvs : sh_x;
    assign dif_c = ge_c ? sh_c - dvs : sh_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            flags_reg <= in_flags;
            dist_reg  <= in_dist;
            num_x_reg <= {in_num_x[lrtp_pkg::NUM_W-2:0], 1'b0};
            num_c_reg <= {in_num_c[lrtp_pkg::NUM_W-2:0], 1'b0};
            rem_x_reg <= dif_x[lrtp_pkg::DREM_W-1:0];
            rem_c_reg <= dif_c[lrtp_pkg::DREM_W-1:0];
            quo_x_reg <= {in_quo_x[lrtp_pkg::NUM_W-2:0], ge_x};
            quo_c_reg <= {in_quo_c[lrtp_pkg::NUM_W-2:0], ge_c};
        end
    end

    assign out_valid = valid_reg;
    assign out_flags = flags_reg;
    assign out_dist  = dist_reg;
    assign out_num_x = num_x_reg;
    assign out_num_c = num_c_reg;
    assign out_rem_x = rem_x_reg;
    assign out_rem_c = rem_c_reg;
    assign out_quo_x = quo_x_reg;
    assign out_quo_c = quo_c_reg;

endmodule

### sim/tb_lens_region_test_and_project.sv
module tb_lens_region_test_and_project;

    localparam int PIPE_CYCLES = 110;
    localparam int STALL_LIMIT = 20000;
    localparam logic [30:0] REG_MAX = 31'h7fff_ffff;
    localparam logic [1:0]  CFG_UNUSED = 2'd3;

    class lens_scoreboard;
        typedef struct {
            logic        in_lens;
            logic [31:0] px;
            logic [31:0] py;
        } proj_t;

        logic [lrtp_pkg::REG_W-1:0] half_w;
        logic [lrtp_pkg::REG_W-1:0] half_h;
        logic [lrtp_pkg::REG_W-1:0] radius;
        proj_t            pending[$];
        int               mismatches;
        int               results_seen;

        function new();
            half_w = lrtp_pkg::REG_ONE;
            half_h = lrtp_pkg::REG_ONE;
            radius = lrtp_pkg::REG_ONE;
            mismatches = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                lrtp_pkg::CFG_HALF_WIDTH:  half_w = data[lrtp_pkg::REG_W-1:0];
                lrtp_pkg::CFG_HALF_HEIGHT: half_h = data[lrtp_pkg::REG_W-1:0];
                lrtp_pkg::CFG_ARC_RADIUS:  radius = data[lrtp_pkg::REG_W-1:0];
                default: ;
            endcase
        endfunction

        static function logic [34:0] floor_root(logic [69:0] v);
            logic [34:0] root;
            logic [69:0] t;
            root = '0;
            for (int b = 34; b >= 0; b--) begin
                t = 70'(root | (35'd1 << b));
                if (t * t <= v) root = t[34:0];
            end
            return root;
        endfunction

        // trunc(v * m / d), sign of v
        static function longint scaled_quot(longint v, logic [63:0] m, logic [34:0] d);
            logic [127:0] num;
            logic [127:0] quo;
            num = 128'(v < 0 ? -v : v) * 128'(m);
            quo = num / 128'(d);
            return v < 0 ? -longint'(quo[63:0]) : longint'(quo[63:0]);
        endfunction

        function proj_t lens_project(logic signed [31:0] x, logic signed [31:0] y);
            proj_t       res;
            longint      xs, ys, wv, hv, rv, off, d, c, px, py, q;
            logic [63:0] ax, ay, ad, ac;
            logic [69:0] rad;
            logic [34:0] root_d;
            logic        up;
            logic        snap;
            xs = x;
            ys = y;
            wv = half_w;
            hv = half_h;
            rv = radius;
            off = rv - hv;
            up = ys >= 0;
            ax = xs < 0 ? -xs : xs;
            ay = ys < 0 ? -ys : ys;
            res.in_lens = 1'b0;
            if (ax <= wv && ay <= hv) begin
                d = longint'(ay) - hv + rv;
                ad = d < 0 ? -d : d;
                if (ax * ax + ad * ad <= 64'(rv) * 64'(rv)) res.in_lens = 1'b1;
            end
            c = up ? ys + off : ys - off;
            ac = c < 0 ? -c : c;
            rad = 70'(ax) * 70'(ax) + 70'(ac) * 70'(ac);
            root_d = floor_root(rad);
            if (root_d == 0) begin
                px = 0;
                q = up ? rv : -rv;
            end else begin
                px = scaled_quot(xs, 64'(rv), root_d);
                q = scaled_quot(c, 64'(rv), root_d);
            end
            py = up ? q - off : q + off;
            snap = up ? (py <= 0) : (py >= 0);
            if (snap) begin
                px = px > 0 ? wv : -wv;
                py = 0;
            end
            if (px > 64'sd2147483647) px = 64'sd2147483647;
            if (px < -64'sd2147483648) px = -64'sd2147483648;
            if (py > 64'sd2147483647) py = 64'sd2147483647;
            if (py < -64'sd2147483648) py = -64'sd2147483648;
            res.px = px[31:0];
            res.py = py[31:0];
            return res;
        endfunction

        function void note_point(logic signed [31:0] x, logic signed [31:0] y);
            pending.push_back(lens_project(x, y));
        endfunction

        function void check_result(logic ins, logic [31:0] px, logic [31:0] py);
            proj_t exp_r;
            results_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: result word with none expected");
                return;
            end
            exp_r = pending.pop_front();
            if (ins !== exp_r.in_lens || px !== exp_r.px || py !== exp_r.py) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: inside %0b/%0b x %h/%h y %h/%h (exp/act)",
                             exp_r.in_lens, ins, exp_r.px, px, exp_r.py, py);
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_point_x;
    logic signed [31:0] s_point_y;
    logic               m_valid;
    logic               m_ready;
    logic               m_is_inside;
    logic signed [31:0] m_proj_x;
    logic signed [31:0] m_proj_y;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    lens_scoreboard sb;
    int tx_idle;
    int rx_idle;
    int idle_cycles;
    int points_sent;

    lens_region_test_and_project u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_point_x   (s_point_x),
        .s_point_y   (s_point_y),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_is_inside (m_is_inside),
        .m_proj_x    (m_proj_x),
        .m_proj_y    (m_proj_y),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_point(s_point_x, s_point_y);
            if (m_valid && m_ready) sb.check_result(m_is_inside, m_proj_x, m_proj_y);
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic send_point(logic signed [31:0] x, logic signed [31:0] y);
        while ($urandom_range(99) < tx_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_point_x <= x;
        s_point_y <= y;
        do @(posedge aclk); while (!(s_valid && s_ready));
        points_sent++;
    endtask

    // hold until the pipe is empty, then write one register
    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (PIPE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= {1'($urandom_range(1)), val};
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    task automatic set_lens(logic [30:0] w, logic [30:0] h, logic [30:0] r);
        write_reg(lrtp_pkg::CFG_HALF_WIDTH, w);
        write_reg(lrtp_pkg::CFG_HALF_HEIGHT, h);
        write_reg(lrtp_pkg::CFG_ARC_RADIUS, r);
        // unused index must leave the registers alone
        write_reg(CFG_UNUSED, 31'($urandom));
    endtask

    task automatic send_near(longint span);
        longint ux, uy;
        ux = $urandom_range(0, 32'(span));
        uy = $urandom_range(0, 32'(span));
        if ($urandom_range(1)) ux = -ux;
        if ($urandom_range(1)) uy = -uy;
        send_point(32'(ux), 32'(uy));
    endtask

    task automatic random_points(int count);
        longint span;
        span = sb.half_w > sb.radius ? sb.half_w : sb.radius;
        span = span * 2 + 8;
        if (span > 64'h7fff_ffff) span = 64'h7fff_ffff;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 70) send_near(span);
            else send_point($urandom, $urandom);
        end
    endtask

    task automatic directed_points();
        logic signed [31:0] w, h;
        w = 32'(sb.half_w);
        h = 32'(sb.half_h);
        send_point(0, 0);
        send_point(w, 0);
        send_point(-w, 0);
        send_point(0, h);
        send_point(0, -h);
        send_point(w, h);
        send_point(-w, -h);
        send_point(32'sh7fff_ffff, 32'sh7fff_ffff);
        send_point(32'sh8000_0000, 32'sh8000_0000);
        send_point(32'sh7fff_ffff, 32'sh8000_0000);
        send_point(32'sh8000_0000, 0);
        send_point(0, 32'sh7fff_ffff);
        send_point(-1, -1);
        send_point(1, 1);
        // arc centers on each side
        send_point(0, 32'(longint'(sb.half_h) - longint'(sb.radius)));
        send_point(0, 32'(longint'(sb.radius) - longint'(sb.half_h)));
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_point_x = '0;
        s_point_y = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = lrtp_pkg::CFG_HALF_WIDTH;
        cfg_data = '0;
        idle_cycles = 0;
        points_sent = 0;
        tx_idle = 34;
        rx_idle = 75;
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values first, where the upper arc center sits at the origin
        directed_points();
        random_points(100);

        set_lens(31'h0002_0000, 31'h0001_0000, 31'h0002_8000);
        directed_points();
        random_points(110);

        tx_idle = 75;
        rx_idle = 34;
        set_lens(31'h0001_0000, 31'h0002_0000, 31'h0000_8000);
        directed_points();
        random_points(100);

        set_lens(REG_MAX, REG_MAX, REG_MAX);
        directed_points();
        random_points(100);

        tx_idle = 0;
        rx_idle = 0;
        set_lens(31'd1, 31'd1, 31'd1);
        directed_points();
        random_points(60);

        set_lens(31'h0003_0000, 31'h0000_4000, 31'd0);
        directed_points();
        random_points(60);

        set_lens(31'h0000_1234, REG_MAX, 31'h0123_4567);
        random_points(80);

        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (PIPE_CYCLES) @(posedge aclk);

        $display("Sent %0d points over 7 lens shapes and 3 flow-control mixes",
                 points_sent);
        $display("%0d results checked", sb.results_seen);
        if (sb.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
